// ===== src/configurable_crc_engine_core_defines.svh =====
// Assertion macros shared by the CRC engine files.
`ifndef CONFIGURABLE_CRC_ENGINE_CORE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CCRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define CCRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ccrc_pkg.sv =====
package ccrc_pkg;

   localparam int RegBitsDefault = 64;
   localparam int RegMaxBits     = 64;
   localparam int ShiftBits      = $clog2(RegMaxBits);
   localparam int WidthBits      = 7;
   localparam int KindBits       = 2;
   localparam int ByteBits       = 8;
   localparam int ChecksumBits   = 64;
   localparam int CsrIndexBits   = 3;
   localparam int CsrDataBits    = 64;

   // word kinds
   localparam logic [KindBits-1:0] KindAbsorb      = 2'd0;
   localparam logic [KindBits-1:0] KindAbsorbFinal = 2'd1;
   localparam logic [KindBits-1:0] KindFinal       = 2'd2;

   // register indexes
   localparam logic [CsrIndexBits-1:0] CsrCrcWidth      = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrPolynomial    = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrInitialValue  = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrReflectInput  = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrReflectOutput = 3'd4;
   localparam logic [CsrIndexBits-1:0] CsrFinalXor      = 3'd5;

   // reset configuration: CRC-32
   localparam logic [WidthBits-1:0]  DefaultCrcWidth      = 7'd32;
   localparam logic [RegMaxBits-1:0] DefaultPolynomial    = 64'h0000_0000_04C1_1DB7;
   localparam logic [RegMaxBits-1:0] DefaultInitialValue  = 64'h0000_0000_FFFF_FFFF;
   localparam logic                  DefaultReflectInput  = 1'b1;
   localparam logic                  DefaultReflectOutput = 1'b1;
   localparam logic [RegMaxBits-1:0] DefaultFinalXor      = 64'h0000_0000_FFFF_FFFF;

   // configuration brought into register alignment, low REG_BITS bits used
   typedef struct packed {
      logic [RegMaxBits-1:0] poly_al;
      logic [RegMaxBits-1:0] init_al;
      logic [RegMaxBits-1:0] xor_mask;
      logic [RegMaxBits-1:0] width_mask;
      logic [ShiftBits-1:0]  shift_dn;
      logic                  rin;
      logic                  rout;
      logic                  rev_fin;
   } cfg_derived_type;

endpackage

// ===== src/ccrc_channels.sv =====
interface ccrc_req_if;
   logic                           valid;
   logic                           ready;
   logic [ccrc_pkg::KindBits-1:0]  kind;
   logic [ccrc_pkg::ByteBits-1:0]  data_byte;
   modport source(output valid, output kind, output data_byte, input ready);
   modport sink(input valid, input kind, input data_byte, output ready);
endinterface

interface ccrc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ccrc_pkg::ChecksumBits-1:0] checksum;
   modport source(output valid, output checksum, input ready);
   modport sink(input valid, input checksum, output ready);
endinterface

interface ccrc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ccrc_pkg::CsrIndexBits-1:0] index;
   logic [ccrc_pkg::CsrDataBits-1:0]  wdata;
   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

// ===== src/ccrc_cfg.sv =====
module ccrc_cfg #(
   parameter int REG_BITS = ccrc_pkg::RegBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   ccrc_csr_if.sink                  csr,
   output ccrc_pkg::cfg_derived_type derived,
   output logic                      reload
);

   localparam int RW = REG_BITS;
   localparam int SW = $clog2(REG_BITS);
   localparam int WW = $clog2(REG_BITS + 1);

   logic [ccrc_pkg::WidthBits-1:0] width_ff, width_in;
   logic [RW-1:0]                  poly_ff, poly_in;
   logic [RW-1:0]                  init_ff, init_in;
   logic                           rin_ff, rin_in;
   logic                           rout_ff, rout_in;
   logic [RW-1:0]                  fxor_ff, fxor_in;
   logic                           reload_ff, reload_in;
   ccrc_pkg::cfg_derived_type      derived_ff, derived_in;

   logic                           cfg_hit;
   logic [WW-1:0]                  eff_w;
   logic [WW-1:0]                  shift_full;
   logic [SW-1:0]                  shift;
   logic [RW-1:0]                  wmask;

   function automatic logic [RW-1:0] reverse_bits(input logic [RW-1:0] v);
      logic [RW-1:0] r;
      for (int i = 0; i < RW; i++) begin
         r[i] = v[RW-1-i];
      end
      return r;
   endfunction

   function automatic logic [RW-1:0] align(input logic [RW-1:0] v, input logic [RW-1:0] wm,
                                           input logic [SW-1:0] sh, input logic ri);
      logic [RW-1:0] t;
      t = (v & wm) << sh;
      return ri ? reverse_bits(t) : t;
   endfunction

   assign csr.ready = 1'b1;

   // next raw configuration
   always_comb begin
      width_in = width_ff;
      poly_in  = poly_ff;
      init_in  = init_ff;
      rin_in   = rin_ff;
      rout_in  = rout_ff;
      fxor_in  = fxor_ff;
      cfg_hit  = 1'b0;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            ccrc_pkg::CsrCrcWidth: begin
               width_in = csr.wdata[ccrc_pkg::WidthBits-1:0];
               cfg_hit  = 1'b1;
            end
            ccrc_pkg::CsrPolynomial: begin
               poly_in = csr.wdata[RW-1:0];
               cfg_hit = 1'b1;
            end
            ccrc_pkg::CsrInitialValue: begin
               init_in = csr.wdata[RW-1:0];
               cfg_hit = 1'b1;
            end
            ccrc_pkg::CsrReflectInput: begin
               rin_in  = csr.wdata[0];
               cfg_hit = 1'b1;
            end
            ccrc_pkg::CsrReflectOutput: begin
               rout_in = csr.wdata[0];
               cfg_hit = 1'b1;
            end
            ccrc_pkg::CsrFinalXor: begin
               fxor_in = csr.wdata[RW-1:0];
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      if (reset) begin
         width_in = ccrc_pkg::DefaultCrcWidth;
         poly_in  = ccrc_pkg::DefaultPolynomial[RW-1:0];
         init_in  = ccrc_pkg::DefaultInitialValue[RW-1:0];
         rin_in   = ccrc_pkg::DefaultReflectInput;
         rout_in  = ccrc_pkg::DefaultReflectOutput;
         fxor_in  = ccrc_pkg::DefaultFinalXor[RW-1:0];
      end
      reload_in = reset || cfg_hit;
   end

   // clamp width and align the operands to the register
   always_comb begin
      if (width_in == '0) begin
         eff_w = WW'(1);
      end else if (width_in > ccrc_pkg::WidthBits'(REG_BITS)) begin
         eff_w = WW'(REG_BITS);
      end else begin
         eff_w = width_in[WW-1:0];
      end
      shift_full = WW'(REG_BITS) - eff_w;
      shift      = shift_full[SW-1:0];
      wmask      = {RW{1'b1}} >> shift;

      derived_in            = '0;
      derived_in.poly_al[RW-1:0]    = align(poly_in, wmask, shift, rin_in);
      derived_in.init_al[RW-1:0]    = align(init_in, wmask, shift, rin_in);
      derived_in.xor_mask[RW-1:0]   = fxor_in & wmask;
      derived_in.width_mask[RW-1:0] = wmask;
      derived_in.shift_dn[SW-1:0]   = shift;
      derived_in.rin                = rin_in;
      derived_in.rout               = rout_in;
      derived_in.rev_fin            = rin_in ^ rout_in;
   end

   always_ff @(posedge clock) begin
      width_ff   <= width_in;
      poly_ff    <= poly_in;
      init_ff    <= init_in;
      rin_ff     <= rin_in;
      rout_ff    <= rout_in;
      fxor_ff    <= fxor_in;
      reload_ff  <= reload_in;
      derived_ff <= derived_in;
   end

   assign derived = derived_ff;
   assign reload  = reload_ff;

endmodule

// ===== src/ccrc_dp.sv =====
module ccrc_dp #(
   parameter int REG_BITS = ccrc_pkg::RegBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   ccrc_req_if.sink                  req,
   ccrc_rsp_if.source                rsp,
   input  ccrc_pkg::cfg_derived_type derived,
   input  logic                      reload
);

   localparam int RW = REG_BITS;
   localparam int SW = $clog2(REG_BITS);

   logic                            s1_valid_ff, s1_valid_in;
   logic [ccrc_pkg::KindBits-1:0]   s1_kind_ff;
   logic [ccrc_pkg::ByteBits-1:0]   s1_data_ff;
   logic [RW-1:0]                   crc_ff, crc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ccrc_pkg::ChecksumBits-1:0] checksum_ff, checksum_in;

   logic [RW-1:0] poly, init, xmask, wmask;
   logic [SW-1:0] shift;
   logic [RW-1:0] crc_cur;
   logic [RW-1:0] r_abs;
   logic [RW-1:0] fin_src;
   logic [RW-1:0] fin;
   logic          emits;
   logic          out_free;
   logic          go;
   logic          take;

   function automatic logic [RW-1:0] reverse_bits(input logic [RW-1:0] v);
      logic [RW-1:0] r;
      for (int i = 0; i < RW; i++) begin
         r[i] = v[RW-1-i];
      end
      return r;
   endfunction

   assign poly  = derived.poly_al[RW-1:0];
   assign init  = derived.init_al[RW-1:0];
   assign xmask = derived.xor_mask[RW-1:0];
   assign wmask = derived.width_mask[RW-1:0];
   assign shift = derived.shift_dn[SW-1:0];

   assign crc_cur  = reload ? init : crc_ff;
   assign emits    = (s1_kind_ff == ccrc_pkg::KindAbsorbFinal) ||
                     (s1_kind_ff == ccrc_pkg::KindFinal);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign go       = s1_valid_ff && (!emits || out_free);
   assign req.ready = !s1_valid_ff || go;
   assign take     = req.valid && req.ready;

   // eight XOR-shift steps, one per message bit
   always_comb begin
      if (derived.rin) begin
         r_abs = crc_cur ^ RW'(s1_data_ff);
         for (int i = 0; i < 8; i++) begin
            r_abs = (r_abs >> 1) ^ (r_abs[0] ? poly : '0);
         end
      end else begin
         r_abs = crc_cur ^ (RW'(s1_data_ff) << (RW - 8));
         for (int i = 0; i < 8; i++) begin
            r_abs = (r_abs << 1) ^ (r_abs[RW-1] ? poly : '0);
         end
      end
   end

   always_comb begin
      fin_src = (s1_kind_ff == ccrc_pkg::KindFinal) ? crc_cur : r_abs;
      fin     = derived.rev_fin ? reverse_bits(fin_src) : fin_src;
      if (!derived.rout) begin
         fin = fin >> shift;
      end
      fin = (fin ^ xmask) & wmask;
   end

   always_comb begin
      crc_in = crc_cur;
      if (go) begin
         case (s1_kind_ff)
            ccrc_pkg::KindAbsorb:      crc_in = r_abs;
            ccrc_pkg::KindAbsorbFinal: crc_in = init;
            ccrc_pkg::KindFinal:       crc_in = init;
            default:                   crc_in = crc_cur;
         endcase
      end

      if (take) begin
         s1_valid_in = 1'b1;
      end else if (go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      checksum_in = checksum_ff;
      if (go && emits) begin
         rsp_valid_in = 1'b1;
         checksum_in  = '0;
         checksum_in[RW-1:0] = fin;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_kind_ff <= req.kind;
         s1_data_ff <= req.data_byte;
      end
      crc_ff      <= crc_in;
      checksum_ff <= checksum_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.checksum = checksum_ff;

endmodule

// ===== src/configurable_crc_engine_core.sv =====
// Configurable CRC engine (Rocksoft model), CRC width 1 to REG_BITS. Each request word carries
// a kind and a message byte: absorb, absorb then finalize, or finalize only; kind 3 is dropped.
// A response word with the checksum (CRC width bits, upper bits zero) comes out for every
// finalize, after which the engine restarts from the initial value. Throughput is one word per
// clock unless a finalize stalls on rsp_chan; results pass the input and output registers. The
// rate is set by the single compute stage, which reads the CRC register, runs eight XOR-shift
// steps and writes it back in the same cycle. The csr channel is always ready; any write to a
// known register restarts the CRC from the new initial value and takes effect for a word taken
// on the next clock. Write registers only while no word is in flight. Reset loads CRC-32.
`include "configurable_crc_engine_core_defines.svh"

module configurable_crc_engine_core #(
   parameter int REG_BITS = ccrc_pkg::RegBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   ccrc_req_if.sink   req_chan,
   ccrc_rsp_if.source rsp_chan,
   ccrc_csr_if.sink   csr_chan
);

   // aligned configuration and the restart strobe
   ccrc_pkg::cfg_derived_type derived;
   logic                      reload;

   // Hold the raw registers and precompute the register-aligned polynomial,
   // initial value, masks and finalize shift, so the datapath sees no barrel
   // shift ahead of the XOR-shift steps.
   ccrc_cfg #(
      .REG_BITS (REG_BITS)
   ) u_cfg (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_chan),
      .derived (derived),
      .reload  (reload)
   );

   // Input register, CRC update and finalize, output register. The output register
   // parts the two sides: a word is taken while a result waits unless a finalize is held.
   ccrc_dp #(
      .REG_BITS (REG_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .derived (derived),
      .reload  (reload)
   );

   // Stall on the request side comes only from a result that is not taken.
   `CCRC_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_chan.ready,
                      rsp_chan.valid && !rsp_chan.ready, "ccrc: request stall without backpressure")

   // A fresh result always stems from a taken word that passed the input and output registers.
   `CCRC_ASSERT_IMPLY(a_rsp_latency, clock, reset, $rose(rsp_chan.valid),
                      $past(req_chan.valid && req_chan.ready, 2), "ccrc: result without request")

   // Checksum never carries bits above the register width.
   `CCRC_ASSERT_IMPLY(a_rsp_width, clock, reset, rsp_chan.valid,
                      (rsp_chan.checksum >> REG_BITS) == '0, "ccrc: checksum too wide")

endmodule
